// File: src/cbb_pkg.sv
// shared types and constants for the clipped 3x3 box blur
package cbb_pkg;

  localparam int MaxSide = 1024;
  localparam int ChanBits = 16;
  localparam int CoordBits = 10;
  localparam int AddrBits = $clog2(MaxSide);
  localparam int SizeBits = 11;
  localparam int SumBits = ChanBits + 4;
  localparam int QueueDepth = 4;
  localparam int QueuePtrBits = 2;
  localparam int RecipBits = 25;
  localparam int RecipShift = 24;

  typedef logic [ChanBits-1:0] chan_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } pix_t;

  // one 3x3 window snapshot plus the position of the pixel that completed it
  typedef struct packed {
    pix_t [8:0] win;          // index a*3+b: row r-2+a, column c-2+b
    logic [CoordBits-1:0] row;
    logic [CoordBits-1:0] col;
    logic last_row;
    logic last_col;
  } job_t;

  // reciprocal of count, 2^24/cnt rounded up; exact for any sum of up to nine channels
  function automatic logic [RecipBits-1:0] recip(input logic [3:0] cnt);
    logic [RecipBits-1:0] v;
    begin
      case (cnt)
        4'd1: v = 25'd16777216;
        4'd2: v = 25'd8388608;
        4'd3: v = 25'd5592406;
        4'd4: v = 25'd4194304;
        4'd6: v = 25'd2796203;
        4'd9: v = 25'd1864136;
        default: v = 25'd16777216;
      endcase
      return v;
    end
  endfunction

endpackage

// File: src/cbb_front.sv
// front end: position tracking, line stores and window capture
module cbb_front import cbb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [SizeBits-1:0] cfg_size,
  input  logic in_take,
  input  pix_t in_pix,
  output logic job_valid,
  output job_t job
);

  logic [AddrBits-1:0] side_m1;
  logic [CoordBits-1:0] row, col;
  logic [CoordBits-1:0] row_next, col_next;
  pix_t older [MaxSide];
  pix_t newer [MaxSide];
  pix_t wc [6];
  // stage 1 registers
  logic s1_valid;
  pix_t s1_pix;
  logic [CoordBits-1:0] s1_row, s1_col;
  logic s1_lr, s1_lc;
  pix_t s1_old, s1_new;
  pix_t s1_old_raw, s1_fwd_pix;
  logic s1_fwd;
  pix_t [8:0] w;

  // side register, clamped to 1..MaxSide
  always_ff @(posedge clk) begin
    if (rst) begin
      side_m1 <= AddrBits'(MaxSide - 1);
    end else if (cfg_we) begin
      if (cfg_size == '0) side_m1 <= '0;
      else if (cfg_size > SizeBits'(MaxSide)) side_m1 <= AddrBits'(MaxSide - 1);
      else side_m1 <= AddrBits'(cfg_size - 1'b1);
    end
  end

  // raster position
  always_comb begin
    row_next = row;
    col_next = col;
    if (col == CoordBits'(side_m1)) begin
      col_next = '0;
      row_next = (row == CoordBits'(side_m1)) ? '0 : row + 1'b1;
    end else begin
      col_next = col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row <= '0;
      col <= '0;
    end else if (in_take) begin
      row <= row_next;
      col <= col_next;
    end
  end

  // line stores: registered reads; the older store takes the registered newer word in the cycle after it is read
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_old_raw <= older[col];
      s1_new <= newer[col];
      newer[col] <= in_pix;
      s1_fwd <= s1_valid && (s1_col == col);
      s1_fwd_pix <= s1_new;
      s1_pix <= in_pix;
      s1_row <= row;
      s1_col <= col;
      s1_lr <= (row == CoordBits'(side_m1));
      s1_lc <= (col == CoordBits'(side_m1));
    end
    if (s1_valid) older[s1_col] <= s1_new;
  end

  // bypass for a column reread while its older entry is being written
  assign s1_old = s1_fwd ? s1_fwd_pix : s1_old_raw;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= in_take;
  end

  // window assembly from the column shift registers
  always_comb begin
    w[0] = wc[0]; w[3] = wc[1]; w[6] = wc[2];
    w[1] = wc[3]; w[4] = wc[4]; w[7] = wc[5];
    w[2] = s1_old; w[5] = s1_new; w[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      wc[0] <= wc[3]; wc[1] <= wc[4]; wc[2] <= wc[5];
      wc[3] <= s1_old; wc[4] <= s1_new; wc[5] <= s1_pix;
      job.win <= w;
      job.row <= s1_row;
      job.col <= s1_col;
      job.last_row <= s1_lr;
      job.last_col <= s1_lc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) job_valid <= 1'b0;
    else job_valid <= s1_valid;
  end

endmodule

// File: src/cbb_queue.sv
// small fifo of window jobs between front and back
module cbb_queue import cbb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic empty,
  output logic [QueuePtrBits:0] count,
  output job_t head
);

  job_t mem [QueueDepth];
  logic [QueuePtrBits-1:0] wp, rp;

  assign empty = (count == '0);
  assign head = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + (QueuePtrBits+1)'(push) - (QueuePtrBits+1)'(pop);
    end
  end

endmodule

// File: src/cbb_back.sv
// back end: walks the outputs of one job, sums, divides and drives the result word
module cbb_back import cbb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_ready,
  input  job_t job,
  output logic job_pop,
  output logic out_valid,
  input  logic out_stall,
  output logic [CoordBits-1:0] out_row,
  output logic [CoordBits-1:0] out_col,
  output chan_t out_red,
  output chan_t out_green,
  output chan_t out_blue,
  output logic run_end
);

  // walk counters over the clipped output block of the current job
  logic [1:0] ia, ib;        // a0, b0 of the current output
  logic [1:0] ia_hi, ib_hi;
  logic [1:0] ia_lo, ib_lo;
  logic has_out, last_out;
  logic step;
  logic [SumBits-1:0] sr, sg, sb;
  logic [3:0] cnt;
  // stage A: sums
  logic a_valid, a_last;
  logic [SumBits-1:0] a_sr, a_sg, a_sb;
  logic [RecipBits-1:0] a_rc;
  logic [CoordBits-1:0] a_row, a_col;
  // stage B: products
  logic b_valid, b_last;
  logic [SumBits+RecipBits-1:0] b_pr, b_pg, b_pb;
  logic [CoordBits-1:0] b_row, b_col;
  logic adv;
  // actual indices: 3 marks "start at the lower bound"
  logic [1:0] ca, cb;
  // load-time overrides so the counters track the first output
  logic [1:0] na, nb;

  always_comb begin
    ca = (ia == 2'd3) ? ia_lo : ia;
    cb = (ib == 2'd3) ? ib_lo : ib;
  end

  // bounds: a0 from max(0,2-r) to 0 or 2, b0 likewise from max(0,2-c)
  always_comb begin
    ia_lo = (job.row >= CoordBits'(2)) ? 2'd0 : 2'(2 - job.row);
    ib_lo = (job.col >= CoordBits'(2)) ? 2'd0 : 2'(2 - job.col);
    ia_hi = job.last_row ? 2'd2 : 2'd0;
    ib_hi = job.last_col ? 2'd2 : 2'd0;
    has_out = (ia_lo <= ia_hi) && (ib_lo <= ib_hi);
    last_out = (ca == ia_hi) && (cb == ib_hi);
  end

  // pipeline advances when the output register is free
  assign adv = !out_valid || !out_stall;
  assign step = job_ready && adv;
  assign job_pop = step && (!has_out || last_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      ia <= 2'd3;
      ib <= 2'd3;
    end else if (job_pop) begin
      ia <= 2'd3;
      ib <= 2'd3;
    end else if (step) begin
      if (cb == ib_hi) begin
        ib <= 2'd3;
        ia <= ca + 1'b1;
      end else begin
        ib <= cb + 1'b1;
      end
    end
  end

  always_comb begin
    na = ca;
    nb = cb;
  end

  // window sum over rows na..2, cols nb..2
  always_comb begin
    sr = '0; sg = '0; sb = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        if (a >= int'(na) && b >= int'(nb)) begin
          sr = sr + SumBits'(job.win[a*3+b].r);
          sg = sg + SumBits'(job.win[a*3+b].g);
          sb = sb + SumBits'(job.win[a*3+b].b);
        end
      end
    end
    cnt = 4'((3 - na) * (3 - nb));
  end

  // stage A
  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (adv) a_valid <= step && has_out;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_sr <= sr; a_sg <= sg; a_sb <= sb;
      a_rc <= recip(cnt);
      a_row <= job.row - CoordBits'(2) + CoordBits'(na);
      a_col <= job.col - CoordBits'(2) + CoordBits'(nb);
      a_last <= (na == ia_hi) && (nb == ib_hi);
    end
  end

  // stage B: multiply by reciprocal
  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (adv) b_valid <= a_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_pr <= a_sr * a_rc;
      b_pg <= a_sg * a_rc;
      b_pb <= a_sb * a_rc;
      b_row <= a_row; b_col <= a_col; b_last <= a_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= b_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_red <= b_pr[RecipShift +: ChanBits];
      out_green <= b_pg[RecipShift +: ChanBits];
      out_blue <= b_pb[RecipShift +: ChanBits];
      out_row <= b_row;
      out_col <= b_col;
      run_end <= b_last;
    end
  end

endmodule

// File: src/clipped_box_blur_3x3_top.sv
// top level of the clipped 3x3 box blur
//
// Pixels enter in raster order on in_valid/in_stall with red, green, blue.
// The square image side comes from the cfg channel (cfg_valid/cfg_ready,
// cfg_data, 11 bits); a write restarts the frame at (0,0). Zero reads as 1,
// values above 1024 as 1024. Reset sets side 1024 and position (0,0).
// Each result word carries row, column, the three truncated channel means
// over the in-image part of the 3x3 window starting there, and run_end on
// the last word caused by one pixel. Most pixels cause one word, the first
// two rows and columns none, a row end or a pixel of the last row three,
// the final pixel nine.
// One pixel per cycle is taken as long as each pixel yields at most one word
// and out_stall is low; at row ends the back end emits one word per cycle
// while out_stall is low, jobs collect in the job queue (4 entries), and
// in_stall rises while it holds two jobs or more. A stalled out word holds; the
// back end pipeline freezes behind it and the queue absorbs the front's pipeline.
module clipped_box_blur_3x3_top import cbb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [SizeBits-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  chan_t in_red,
  input  chan_t in_green,
  input  chan_t in_blue,
  output logic out_valid,
  input  logic out_stall,
  output logic [CoordBits-1:0] out_row,
  output logic [CoordBits-1:0] out_col,
  output chan_t out_red,
  output chan_t out_green,
  output chan_t out_blue,
  output logic run_end
);

  logic in_take, job_valid, q_empty, pop;
  logic [QueuePtrBits:0] q_count;
  job_t fjob, qhead;
  pix_t in_pix;

  assign cfg_ready = 1'b1;
  assign in_pix = '{r: in_red, g: in_green, b: in_blue};
  // keep room for the two pixels already inside the front pipeline
  assign in_stall = (q_count >= (QueuePtrBits+1)'(QueueDepth - 2));
  assign in_take = in_valid && !in_stall;

  cbb_front u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_valid), .cfg_size(cfg_data),
    .in_take(in_take), .in_pix(in_pix),
    .job_valid(job_valid), .job(fjob)
  );

  cbb_queue u_queue (
    .clk(clk), .rst(rst),
    .push(job_valid), .push_job(fjob),
    .pop(pop), .empty(q_empty), .count(q_count), .head(qhead)
  );

  cbb_back u_back (
    .clk(clk), .rst(rst),
    .job_ready(!q_empty), .job(qhead), .job_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row(out_row), .out_col(out_col),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .run_end(run_end)
  );

endmodule
